// ----- hdl/ttb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants of the timeout timer bank
// Command, result and chain word formats, operation and register codes.
// ----------------------------------------------------------------------------
package ttb_pkg;

  // Default size of the bank and ticks of the 1 ms input per 100 ms step.
  localparam int NUM_TIMERS      = 8;
  localparam int TICKS_PER_TENTH = 100;

  // Only the first eight timers have a bit in the mask registers and can be
  // addressed by the three-bit timer index.
  localparam int MASK_BITS = 8;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_START   = 2'd1,
    FUNC_DISABLE = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_WATCH     = 2'd0,
    CFG_TRIP      = 2'd1,
    CFG_AUTOCLEAR = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    func_e       func;
    logic [2:0]  timer_index;
    logic [31:0] duration_tenths;
  } ttb_cmd_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] start_stamp;
    logic        is_enabled;
    logic        has_timed_out;
    logic        due_now;
    logic        trip_request;
    logic [31:0] tenth_count;
  } ttb_result_t;

  // Mask bits that one cell sees.
  typedef struct packed {
    logic watch;
    logic trip;
    logic autoclear;
  } ttb_cell_cfg_t;

  // The word that travels down the row of cells, gathering its result.
  typedef struct packed {
    func_e       func;
    logic [2:0]  idx;
    logic [31:0] dur;
    logic [31:0] count;
    logic        accepted;
    logic [31:0] stamp;
    logic        en;
    logic        tmo;
    logic        due;
    logic        trip;
  } ttb_word_t;

endpackage

// ----- hdl/timeout_timer_bank.sv -----
// ----------------------------------------------------------------------------
// timeout_timer_bank: bank of one-shot timeout timers
// Tick, start, disable and query commands over a row of timer cells.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Word
// command   in         start_i, busy_o        cmd_i    (ttb_cmd_t)
// result    out        done_o strobe          result_o (ttb_result_t)
// config    in         cfg_we_i, cfg_idx_i    cfg_data_i (8 bits)
//
// A command is taken at a rising edge with start_i high and busy_o low. The
// word then walks down the row of NumTimers cells, one cell per cycle, and
// its result appears on result_o with done_o high for one cycle, once the
// word leaves the last cell. busy_o stays high through the result cycle, so
// the block takes no new command until the last one's result is out.
// Reset is asynchronous and active low; it clears every timer, the
// prescaler and the count, and loads the default masks.
// The receiver cannot stall: done_o is a strobe and is never held.
// ----------------------------------------------------------------------------
module timeout_timer_bank #(
  parameter int NumTimers     = ttb_pkg::NUM_TIMERS,
  parameter int TicksPerTenth = ttb_pkg::TICKS_PER_TENTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  ttb_pkg::ttb_cmd_t    cmd_i,
  output logic                 done_o,
  output ttb_pkg::ttb_result_t result_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  localparam int PresW = (TicksPerTenth > 1) ? $clog2(TicksPerTenth) : 1;
  localparam logic [PresW-1:0] PresLast = PresW'(TicksPerTenth - 1);

  // Mask registers; the user must write them only while the bank is idle, the block itself does not enforce this.
  logic [7:0] watch_q, trip_q, autoclear_q;

  // The 1 ms prescaler and the 100 ms count.
  logic [PresW-1:0] pres_q, pres_d;
  logic [31:0]      count_q, count_d;

  logic accept;
  logic is_tick;

  // Chain of valid flags and words: entry 0 is the word entering the first
  // cell, entry k leaves cell k-1.
  logic [NumTimers:0] valid;
  ttb_pkg::ttb_word_t word [NumTimers+1];

  assign accept  = start_i && !busy_o;
  assign is_tick = (cmd_i.func == ttb_pkg::FUNC_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_q     <= 8'hFF;
      trip_q      <= 8'h00;
      autoclear_q <= 8'h00;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ttb_pkg::CFG_WATCH:     watch_q     <= cfg_data_i;
        ttb_pkg::CFG_TRIP:      trip_q      <= cfg_data_i;
        ttb_pkg::CFG_AUTOCLEAR: autoclear_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // A tick moves the prescaler on; on wrap the count steps. The timers then
  // see the count as it stands after the tick.
  always_comb begin
    pres_d  = pres_q;
    count_d = count_q;
    if (accept && is_tick) begin
      if (pres_q == PresLast) begin
        pres_d  = '0;
        count_d = count_q + 32'd1;
      end else begin
        pres_d = pres_q + PresW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q  <= '0;
      count_q <= '0;
    end else begin
      pres_q  <= pres_d;
      count_q <= count_d;
    end
  end

  // The word launched into the row carries the command and the count.
  always_comb begin
    word[0]          = '0;
    word[0].func     = cmd_i.func;
    word[0].idx      = cmd_i.timer_index;
    word[0].dur      = cmd_i.duration_tenths;
    word[0].count    = count_d;
  end
  assign valid[0] = accept;

  for (genvar g = 0; g < NumTimers; g++) begin : g_cell
    ttb_pkg::ttb_cell_cfg_t cell_cfg;
    if (g < ttb_pkg::MASK_BITS) begin : g_masked
      assign cell_cfg.watch     = watch_q[g];
      assign cell_cfg.trip      = trip_q[g];
      assign cell_cfg.autoclear = autoclear_q[g];
    end else begin : g_unmasked
      // Timers beyond the mask width are never watched, tripped or cleared.
      assign cell_cfg = '0;
    end

    ttb_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid[g]),
      .word_i (word[g]),
      .cfg_i  (cell_cfg),
      .valid_o(valid[g+1]),
      .word_o (word[g+1])
    );
  end

  // Only one command is ever in the row, so the bank is busy while any cell
  // stage holds a valid word, the result cycle included.
  assign busy_o = |valid[NumTimers:1];
  assign done_o = valid[NumTimers];

  always_comb begin
    result_o.accepted      = word[NumTimers].accepted;
    result_o.start_stamp   = word[NumTimers].stamp;
    result_o.is_enabled    = word[NumTimers].en;
    result_o.has_timed_out = word[NumTimers].tmo;
    result_o.due_now       = word[NumTimers].due;
    result_o.trip_request  = word[NumTimers].trip;
    result_o.tenth_count   = word[NumTimers].count;
  end

`ifndef NO_ASSERTIONS
  a_single_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(valid[NumTimers:1]))
    else $error("more than one word in the cell row");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(NumTimers) done_o)
    else $error("result did not appear after the cell row");

  a_pres_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pres_q <= PresLast)
    else $error("prescaler out of range");

  a_stamp_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.accepted |-> result_o.start_stamp == 32'd0)
    else $error("start stamp set without acceptance");

  a_count_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> $stable(count_q) || $past(accept))
    else $error("count moved while a command was in flight");
`endif

endmodule

// ----- hdl/ttb_cell.sv -----
// ----------------------------------------------------------------------------
// ttb_cell: one timer of the timeout timer bank
// Holds one timer's state, acts on the word passing by and hands it on.
// ----------------------------------------------------------------------------
module ttb_cell #(
  parameter int CellIdx = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  ttb_pkg::ttb_word_t     word_i,
  input  ttb_pkg::ttb_cell_cfg_t cfg_i,
  output logic                   valid_o,
  output ttb_pkg::ttb_word_t     word_o
);

  localparam bit         Addressable = (CellIdx < ttb_pkg::MASK_BITS);
  localparam logic [2:0] CellSel     = CellIdx[2:0];

  logic               en_q, en_d;
  logic               flag_q, flag_d;
  logic [31:0]        start_q, start_d;
  logic [31:0]        len_q, len_d;
  logic               valid_q;
  ttb_pkg::ttb_word_t word_q, word_d;

  logic [31:0] elapsed;
  logic        due;
  logic        hit;

  assign elapsed = word_i.count - start_q;
  assign due     = (len_q <= elapsed) && !flag_q;
  assign hit     = Addressable && (word_i.idx == CellSel);

  always_comb begin
    en_d    = en_q;
    flag_d  = flag_q;
    start_d = start_q;
    len_d   = len_q;
    word_d  = word_i;
    if (valid_i) begin
      case (word_i.func)
        ttb_pkg::FUNC_TICK: begin
          if (en_q && cfg_i.watch && due) begin
            flag_d = 1'b1;
            if (cfg_i.trip) begin
              word_d.trip = 1'b1;
            end
            if (cfg_i.autoclear) begin
              en_d    = 1'b0;
              flag_d  = 1'b0;
              start_d = '0;
              len_d   = '0;
            end
          end
        end
        ttb_pkg::FUNC_START: begin
          if (hit && !en_q) begin
            en_d            = 1'b1;
            flag_d          = 1'b0;
            start_d         = word_i.count;
            len_d           = word_i.dur;
            word_d.accepted = 1'b1;
            word_d.stamp    = word_i.count;
          end
        end
        ttb_pkg::FUNC_DISABLE: begin
          if (hit) begin
            en_d    = 1'b0;
            flag_d  = 1'b0;
            start_d = '0;
            len_d   = '0;
          end
        end
        ttb_pkg::FUNC_QUERY: begin
          if (hit) begin
            word_d.en  = en_q;
            word_d.tmo = en_q && flag_q;
            word_d.due = due;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      flag_q  <= 1'b0;
      start_q <= '0;
      len_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      en_q    <= en_d;
      flag_q  <= flag_d;
      start_q <= start_d;
      len_q   <= len_d;
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule
